// ===== rtl/core/rlt_pkg.sv =====
// Shared types and codes for the receive loss tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package rlt_pkg;

	// verdict codes carried in the status field
	localparam logic [2:0] ST_NEW_ORDER = 3'd0;
	localparam logic [2:0] ST_NEW_GAP   = 3'd1;
	localparam logic [2:0] ST_RECOVERED = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_TOO_FAR   = 3'd4;

	// result kinds
	localparam logic KIND_REPORT  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the accepted item, start the bitmap read
		logic classify;  // latch the verdict class
		logic mark;      // mark one skipped number and send its report
		logic verdict;   // apply the state update and send the verdict
	} rlt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic gap_open;  // item is new and skips at least one number
		logic gap_last;  // the number being marked is the last one skipped
		logic out_free;  // output register can take a result this cycle
	} rlt_stat_t;

endpackage

// ===== rtl/core/rlt_ctrl.sv =====
// Controller state machine for the receive loss tracker.
// Depends on rlt_pkg for the command and status structs.
module rlt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rlt_pkg::rlt_stat_t   stat,
	output rlt_pkg::rlt_cmd_t    cmd
);
	import rlt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_CHECK   = 4'b0010,
		S_GAP     = 4'b0100,
		S_VERDICT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n      = state_q;
		cmd          = '0;
		in_stall     = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.classify = 1'b1;
				state_n      = stat.gap_open ? S_GAP : S_VERDICT;
			end
			S_GAP: begin
				// one skipped number per free output slot
				if (stat.out_free) begin
					cmd.mark = 1'b1;
					if (stat.gap_last) begin
						state_n = S_VERDICT;
					end
				end
			end
			S_VERDICT: begin
				if (stat.out_free) begin
					cmd.verdict = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== rtl/core/rlt_datapath.sv =====
// Datapath for the receive loss tracker: missing bitmap, tracking registers
// and the output register. Depends on rlt_pkg; driven by rlt_ctrl commands.
module rlt_datapath #(
	parameter int SEQ_SPACE = 65536,
	parameter int MAX_GAP   = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlt_pkg::rlt_cmd_t    cmd,
	output rlt_pkg::rlt_stat_t   stat,
	input  logic [15:0]          seq_number,
	input  logic                 final_packet,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 result_kind,
	output logic [15:0]          seq_out,
	output logic                 store_payload,
	output logic [2:0]           status,
	output logic [16:0]          missing_count,
	output logic                 transfer_done,
	output logic                 last_in_run
);
	import rlt_pkg::*;

	localparam int AW = $clog2(SEQ_SPACE);
	localparam int XW = 21;

	// bitmap: an entry below next expected has always been written, anything
	// at or above it is never read as a hit
	logic              map_q [SEQ_SPACE];
	logic              rd_q;

	logic [15:0]       seq_q;
	logic              final_q;
	logic [2:0]        status_q;
	logic              store_q;
	logic [16:0]       next_q;
	logic [16:0]       total_q;
	logic              final_seen_q;
	logic              finished_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [15:0]       seq_out_q;
	logic              store_out_q;
	logic [2:0]        status_out_q;
	logic [16:0]       count_out_q;
	logic              done_out_q;
	logic              last_out_q;

	logic [XW-1:0]     in_x;
	logic [XW-1:0]     seq_x;
	logic [XW-1:0]     next_x;
	logic [16:0]       seq_17;
	logic [16:0]       gap;
	logic              is_new;
	logic              too_far;
	logic              out_of_space;
	logic [2:0]        cls_status;
	logic              cls_store;
	logic [16:0]       total_dec;
	logic              upd;
	logic              final_seen_n;
	logic              finished_n;
	logic              out_free;

	assign in_x   = {5'b0, seq_number};
	assign seq_x  = {5'b0, seq_q};
	assign next_x = {4'b0, next_q};
	assign seq_17 = {1'b0, seq_q};

	assign out_of_space = (seq_x >= XW'(SEQ_SPACE));
	assign is_new       = (seq_17 >= next_q);
	assign gap          = seq_17 - next_q;
	assign too_far      = (gap > 17'(MAX_GAP));

	always_comb begin
		cls_status = ST_DUPLICATE;
		cls_store  = 1'b0;
		if (finished_q) begin
			cls_status = ST_DUPLICATE;
		end else if (out_of_space) begin
			cls_status = ST_TOO_FAR;
		end else if (is_new) begin
			if (too_far) begin
				cls_status = ST_TOO_FAR;
			end else begin
				cls_status = (gap == 17'd0) ? ST_NEW_ORDER : ST_NEW_GAP;
				cls_store  = 1'b1;
			end
		end else if (rd_q) begin
			cls_status = ST_RECOVERED;
			cls_store  = 1'b1;
		end
	end

	// verdict-time update of the tracking state
	assign total_dec = (status_q == ST_RECOVERED && total_q != 17'd0) ?
		total_q - 17'd1 : total_q;
	assign upd          = !finished_q && (status_q != ST_TOO_FAR);
	assign final_seen_n = final_seen_q | (upd & final_q);
	assign finished_n   = finished_q | (upd && final_seen_n && total_dec == 17'd0);

	assign out_free      = !out_valid_q || !out_stall;
	assign stat.out_free = out_free;
	assign stat.gap_open = (cls_status == ST_NEW_GAP);
	assign stat.gap_last = ((next_q + 17'd1) == seq_17);

	// bitmap port: read on accept, mark skipped numbers, clear on store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= map_q[in_x[AW-1:0]];
		end
		if (cmd.mark) begin
			map_q[next_x[AW-1:0]] <= 1'b1;
		end else if (cmd.verdict && store_q) begin
			map_q[seq_x[AW-1:0]] <= 1'b0;
		end
	end

	// item payload and class
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q   <= seq_number;
			final_q <= final_packet;
		end
		if (cmd.classify) begin
			status_q <= cls_status;
			store_q  <= cls_store;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q       <= '0;
			total_q      <= '0;
			final_seen_q <= 1'b0;
			finished_q   <= 1'b0;
		end else if (cmd.mark) begin
			next_q  <= next_q + 17'd1;
			total_q <= total_q + 17'd1;
		end else if (cmd.verdict) begin
			if (status_q == ST_NEW_ORDER || status_q == ST_NEW_GAP) begin
				next_q <= seq_17 + 17'd1;
			end
			total_q      <= total_dec;
			final_seen_q <= final_seen_n;
			finished_q   <= finished_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.mark || cmd.verdict) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark) begin
			kind_q       <= KIND_REPORT;
			seq_out_q    <= next_q[15:0];
			store_out_q  <= 1'b0;
			status_out_q <= ST_NEW_ORDER;
			count_out_q  <= total_q + 17'd1;
			done_out_q   <= finished_q;
			last_out_q   <= 1'b0;
		end else if (cmd.verdict) begin
			kind_q       <= KIND_VERDICT;
			seq_out_q    <= seq_q;
			store_out_q  <= store_q;
			status_out_q <= status_q;
			count_out_q  <= total_dec;
			done_out_q   <= finished_n;
			last_out_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign seq_out       = seq_out_q;
	assign store_payload = store_out_q;
	assign status        = status_out_q;
	assign missing_count = count_out_q;
	assign transfer_done = done_out_q;
	assign last_in_run   = last_out_q;

endmodule

// ===== rtl/core/receive_loss_tracker.sv =====
// Receive loss tracker for a selective-repeat transfer.
// Input channel: in_valid/in_stall with seq_number and final_packet; one item
// per received packet. Output channel: out_valid/out_stall, each result field
// on a port of its own. Each input item yields zero or more missing-number
// reports (result_kind 0), one per number skipped by a forward jump, then one
// verdict (result_kind 1, last_in_run 1).
// Steps: an item is accepted in the idle state; the load step captures it and
// starts the registered bitmap read, the classify step latches the verdict
// class, then a gap step marks each skipped number (up to MAX_GAP) and loads
// its report, and the verdict step loads the verdict into the output register.
// Report and verdict steps wait for a free output slot. The block takes the
// next item the cycle after the verdict is loaded.
// A stalled receiver holds the output register; the controller then waits
// before loading each further result, and a held verdict does not block
// acceptance of the next item.
// Reset clears the tracking registers and the output valid; the bitmap needs
// no clearing pass, as entries at or above the next expected number are
// never read as marked and every entry below it has been written.
module receive_loss_tracker #(
	parameter int SEQ_SPACE = 65536,
	parameter int MAX_GAP   = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] seq_number,
	input  logic        final_packet,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [15:0] seq_out,
	output logic        store_payload,
	output logic [2:0]  status,
	output logic [16:0] missing_count,
	output logic        transfer_done,
	output logic        last_in_run
);
	import rlt_pkg::*;

	rlt_cmd_t  cmd;
	rlt_stat_t stat;

	rlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rlt_datapath #(
		.SEQ_SPACE (SEQ_SPACE),
		.MAX_GAP   (MAX_GAP)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.seq_number    (seq_number),
		.final_packet  (final_packet),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.seq_out       (seq_out),
		.store_payload (store_payload),
		.status        (status),
		.missing_count (missing_count),
		.transfer_done (transfer_done),
		.last_in_run   (last_in_run)
	);

	// an accepted item keeps the input side busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on two consecutive cycles");

	// done implies nothing is missing
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_done |-> missing_count == 17'd0)
		else $error("transfer done with numbers still missing");

	// reports never store, never end a run and carry a fixed status
	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_REPORT |->
		!store_payload && !last_in_run && status == ST_NEW_ORDER)
		else $error("malformed missing-number report");

	// a verdict always closes the run
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_VERDICT |-> last_in_run)
		else $error("verdict without end of run");

endmodule

// ===== tb/tb_receive_loss_tracker.sv =====
// Self-checking bench for receive_loss_tracker: directed and random packet streams.
// Holds its own loss ledger that predicts every report and verdict; needs rlt_pkg and the RTL.
import rlt_pkg::*;

typedef struct packed {
	logic        kind;
	logic [15:0] seq;
	logic        store;
	logic [2:0]  code;
	logic [16:0] count;
	logic        done;
	logic        last;
} loss_result_t;

class loss_ledger;
	localparam int GAP_LIMIT = 63;

	loss_result_t due_results[$];
	bit           gap_map [65536];
	bit [16:0]    next_seq;
	bit [15:0]    low_mark;
	bit [15:0]    high_mark;
	bit [16:0]    lost_total;
	bit           last_seen;
	bit           done;
	int unsigned  holes[$];
	int unsigned  errors;
	int unsigned  results;
	int unsigned  reports;
	int unsigned  peak_lost;

	function void add(logic kind, logic [15:0] seq, logic store, logic [2:0] code, logic last);
		loss_result_t r;
		r.kind  = kind;
		r.seq   = seq;
		r.store = store;
		r.code  = code;
		r.count = lost_total;
		r.done  = done;
		r.last  = last;
		due_results.push_back(r);
	endfunction

	// work out every result one accepted packet causes
	function void note_packet(bit [15:0] s, bit fin);
		bit [16:0] want = {1'b0, s};
		bit [2:0]  code;
		bit        keep = 1'b0;
		if (done) begin
			add(KIND_VERDICT, s, 1'b0, ST_DUPLICATE, 1'b1);
			return;
		end
		if (want >= next_seq) begin
			if (want - next_seq > GAP_LIMIT) begin
				add(KIND_VERDICT, s, 1'b0, ST_TOO_FAR, 1'b1);
				return;
			end
			code = (want == next_seq) ? ST_NEW_ORDER : ST_NEW_GAP;
			while (next_seq < want) begin
				gap_map[next_seq[15:0]] = 1'b1;
				holes.push_back(32'(next_seq));
				if (next_seq[15:0] > high_mark)
					high_mark = next_seq[15:0];
				lost_total++;
				// status is zero on reports
				add(KIND_REPORT, next_seq[15:0], 1'b0, ST_NEW_ORDER, 1'b0);
				next_seq++;
			end
			next_seq = want + 17'd1;
			keep = 1'b1;
		end else if (gap_map[s]) begin
			gap_map[s] = 1'b0;
			foreach (holes[i])
				if (holes[i] == s) begin
					holes.delete(i);
					break;
				end
			if (lost_total > 0)
				lost_total--;
			if (s == low_mark && low_mark < 16'hFFFF)
				low_mark++;
			if (s == high_mark && high_mark > 0)
				high_mark--;
			code = ST_RECOVERED;
			keep = 1'b1;
		end else begin
			code = ST_DUPLICATE;
		end
		if (fin)
			last_seen = 1'b1;
		if (last_seen && lost_total == 0)
			done = 1'b1;
		add(KIND_VERDICT, s, keep, code, 1'b1);
		if (holes.size() > peak_lost)
			peak_lost = unsigned'(holes.size());
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want, logic [15:0] seq);
		errors++;
		$display("mismatch on %s: got %0d, want %0d (seq %0d)", what, got, want, seq);
	endtask

	task check_result(loss_result_t got);
		loss_result_t want;
		results++;
		if (got.kind === KIND_REPORT)
			reports++;
		if (due_results.size() == 0) begin
			report("unexpected result", 32'(got.seq), 32'd0, got.seq);
			return;
		end
		want = due_results.pop_front();
		if (got.kind !== want.kind)
			report("result_kind", 32'(got.kind), 32'(want.kind), want.seq);
		if (got.seq !== want.seq)
			report("seq_out", 32'(got.seq), 32'(want.seq), want.seq);
		if (got.store !== want.store)
			report("store_payload", 32'(got.store), 32'(want.store), want.seq);
		if (got.code !== want.code)
			report("status", 32'(got.code), 32'(want.code), want.seq);
		if (got.count !== want.count)
			report("missing_count", 32'(got.count), 32'(want.count), want.seq);
		if (got.done !== want.done)
			report("transfer_done", 32'(got.done), 32'(want.done), want.seq);
		if (got.last !== want.last)
			report("last_in_run", 32'(got.last), 32'(want.last), want.seq);
	endtask
endclass

module tb_receive_loss_tracker;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] seq_number;
	logic        final_packet;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [15:0] seq_out;
	logic        store_payload;
	logic [2:0]  status;
	logic [16:0] missing_count;
	logic        transfer_done;
	logic        last_in_run;

	loss_ledger  ledger;
	bit          quiet;
	bit          hold_req;
	int unsigned sent;

	receive_loss_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.seq_number(seq_number),
		.final_packet(final_packet),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.seq_out(seq_out),
		.store_payload(store_payload),
		.status(status),
		.missing_count(missing_count),
		.transfer_done(transfer_done),
		.last_in_run(last_in_run)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		loss_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {result_kind, seq_out, store_payload, status, missing_count,
				transfer_done, last_in_run};
			ledger.check_result(got);
		end
	end

	// receiver: short stall bursts, one long hold-off on request
	initial begin : receiver
		int unsigned span;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall = 1'b1;
				for (span = 0; span < HOLD_CYCLES; span++)
					@(negedge clk);
				out_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				span = $urandom_range(1, 7);
				out_stall = 1'b1;
				repeat (span) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// called and returns at a falling edge; leaves valid high for the next item
	task automatic send_item(input logic [15:0] s, input logic fin);
		int unsigned span;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			span = $urandom_range(1, 7);
			in_valid = 1'b0;
			repeat (span) @(negedge clk);
		end
		in_valid = 1'b1;
		seq_number = s;
		final_packet = fin;
		do
			@(posedge clk);
		while (in_stall);
		ledger.note_packet(s, fin);
		sent++;
		@(negedge clk);
	endtask

	// mostly well-formed traffic, some duplicates and stray numbers
	task automatic random_item();
		int unsigned pick;
		logic [16:0] base;
		logic [15:0] s;
		logic        fin;
		base = ledger.next_seq;
		pick = $urandom_range(0, 99);
		fin = 1'b0;
		if (ledger.holes.size() > 40 && pick < 60)
			pick = 70;
		if (pick < 45)
			s = base[15:0];
		else if (pick < 62)
			s = base[15:0] + 16'($urandom_range(1, 8));
		else if (pick < 68)
			s = base[15:0] + 16'($urandom_range(9, 63));
		else if (pick < 84 && ledger.holes.size() != 0)
			s = 16'(ledger.holes[$urandom_range(0, ledger.holes.size() - 1)]);
		else if (pick < 92 && base != 0)
			s = 16'($urandom_range(0, base - 1));
		else begin
			s = 16'($urandom);
			// keep the last flag off anything the block would accept
			if ({1'b0, s} > base + 17'd63)
				fin = 1'($urandom_range(0, 1));
		end
		send_item(s, fin);
	endtask

	initial begin : stimulus
		int unsigned n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		seq_number = '0;
		final_packet = 1'b0;
		ledger = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(16'd0, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd4, 1'b0);     // skip three
		send_item(16'd2, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd2, 1'b0);     // already recovered
		send_item(16'd3, 1'b0);
		send_item(16'd69, 1'b0);    // one past the widest gap
		send_item(16'd68, 1'b0);    // widest gap
		send_item(16'd200, 1'b1);   // rejected, flag ignored
		send_item(16'hFFFF, 1'b1);
		send_item(16'd69, 1'b0);
		send_item(16'd71, 1'b0);
		send_item(16'd67, 1'b0);
		send_item(16'd5, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd70, 1'b0);

		for (n = 0; n < 330; n++) begin
			if (n == 120)
				hold_req = 1'b1;
			random_item();
		end

		// closing: open a gap, flag the end on a duplicate, then fill every hole
		quiet = 1'b1;
		send_item(16'(ledger.next_seq + 17'd5), 1'b0);
		send_item(16'(ledger.next_seq - 17'd1), 1'b1);
		while (ledger.holes.size() != 0)
			send_item(16'(ledger.holes[$urandom_range(0, ledger.holes.size() - 1)]), 1'b0);
		repeat (6) send_item(16'($urandom), 1'($urandom_range(0, 1)));
		in_valid = 1'b0;

		while (ledger.due_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d packets accepted, %0d results checked, %0d of them loss reports",
			sent, ledger.results, ledger.reports);
		$display("up to %0d numbers missing at once; transfer finished: %0d",
			ledger.peak_lost, ledger.done);
		if (ledger.errors == 0)
			$display("tb_receive_loss_tracker OK");
		else
			$display("tb_receive_loss_tracker NOT OK");
		$finish;
	end

	initial begin : watchdog
		#24000000;
		$display("tb_receive_loss_tracker NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/rlt_pkg.sv
rtl/core/rlt_ctrl.sv
rtl/core/rlt_datapath.sv
rtl/core/receive_loss_tracker.sv
tb/tb_receive_loss_tracker.sv
